[hdl/bmpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmpc_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int COLOR_W     = 15;
	localparam int MODE_W      = 4;
	localparam int CFG_AW      = 3;
	localparam int CFG_DW      = 32;

	localparam logic [MODE_W-1:0] MODE_DIRECT  = 4'd3;
	localparam logic [MODE_W-1:0] MODE_PALETTE = 4'd4;

	localparam logic KIND_PAL_WRITE = 1'b0;
	localparam logic KIND_PIXEL     = 1'b1;

	localparam logic [31:0] RED_MASK_RST   = 32'h0000_f800;
	localparam logic [31:0] GREEN_MASK_RST = 32'h0000_07e0;
	localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_001f;

	typedef enum logic [CFG_AW-1:0] {
		REG_SCREEN_MODE = 3'd0,
		REG_BG2_ENABLE  = 3'd1,
		REG_DEPTH_IS_32 = 3'd2,
		REG_RED_MASK    = 3'd3,
		REG_GREEN_MASK  = 3'd4,
		REG_BLUE_MASK   = 3'd5
	} cfg_reg_t;

	// Red and green: mask moved down into the low byte, field moved up again.
	typedef struct packed {
		logic [4:0] sh;
		logic [7:0] m;
	} chan_up_t;

	// Blue: mask moved up until bit 7 is set, field moved down again.
	typedef struct packed {
		logic       ok;
		logic [2:0] sh;
		logic [7:0] m;
	} chan_dn_t;

	typedef struct packed {
		logic     depth_is_32;
		chan_up_t red;
		chan_up_t green;
		chan_dn_t blue;
	} pack_cfg_t;

	typedef struct packed {
		logic               en;
		logic [PAL_AW-1:0]  addr;
		logic [COLOR_W-1:0] data;
	} pal_wr_t;

	function automatic logic [7:0] widen5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic chan_up_t make_up(input logic [31:0] mask);
		chan_up_t   r;
		logic [4:0] top;
		logic [31:0] moved;
		top = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mask[i]) begin
				top = 5'(i);
			end
		end
		if (mask[31:8] == 24'd0) begin
			r.sh = 5'd0;
		end else begin
			r.sh = top - 5'd7;
		end
		moved = mask >> r.sh;
		r.m = moved[7:0];
		return r;
	endfunction

	function automatic chan_dn_t make_dn(input logic [31:0] mask);
		chan_dn_t   r;
		logic [2:0] top;
		logic [7:0] moved;
		top = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				top = 3'(i);
			end
		end
		r.ok = |mask[7:0];
		r.sh = 3'd7 - top;
		moved = mask[7:0] << r.sh;
		r.m = moved;
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/bmpc_palette.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmpc_palette (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bmpc_pkg::pal_wr_t               wr,
	input  wire logic                            rd_en,
	input  wire logic [bmpc_pkg::PAL_AW-1:0]     rd_addr,
	output logic      [bmpc_pkg::COLOR_W-1:0]    rd_data
);

	logic [bmpc_pkg::COLOR_W-1:0] mem [bmpc_pkg::PAL_ENTRIES];
	logic [bmpc_pkg::PAL_ENTRIES-1:0] written_q;
	logic [bmpc_pkg::COLOR_W-1:0] rd_q;
	logic rd_valid_q;

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= written_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

[hdl/bmpc_pack.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmpc_pack (
	input  wire logic [bmpc_pkg::COLOR_W-1:0] color,
	input  wire bmpc_pkg::pack_cfg_t          cfg,
	output logic      [31:0]                  pixel
);

	logic [7:0]  r8;
	logic [7:0]  g8;
	logic [7:0]  b8;
	logic [31:0] r_part;
	logic [31:0] g_part;
	logic [7:0]  b_part;
	logic [15:0] sum16;

	always_comb begin
		r8 = bmpc_pkg::widen5(color[4:0]);
		g8 = bmpc_pkg::widen5(color[9:5]);
		b8 = bmpc_pkg::widen5(color[14:10]);
		r_part = {24'd0, r8 & cfg.red.m} << cfg.red.sh;
		g_part = {24'd0, g8 & cfg.green.m} << cfg.green.sh;
		b_part = cfg.blue.ok ? ((b8 & cfg.blue.m) >> cfg.blue.sh) : 8'd0;
		sum16 = r_part[15:0] + g_part[15:0] + {8'd0, b_part};
		if (cfg.depth_is_32) begin
			pixel = {8'd0, r8, g8, b8};
		end else begin
			pixel = {16'd0, sum16};
		end
	end

endmodule

`default_nettype wire

[hdl/bitmap_mode_pixel_converter.sv]
// Bitmap-mode pixel converter.
// Input channel (in_valid/in_ready): each transaction is either a palette write
// (kind 0: entry_index, entry_color) or a pixel (kind 1: pixel_word). Output
// channel (out_valid/out_ready) carries one pixel_out per pixel that is shown,
// that is background 2 enabled and screen mode 3 (direct) or 4 (paletted).
// Palette writes and pixels in other modes produce no output transaction.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata). The user
// must see that it is written only while no transaction is in flight; the
// block itself does not enforce this. From input acceptance to pixel_out
// valid, a transaction passes the input stage, where the palette memory read
// is registered, then the conversion stage, which ends in the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its pixel and the input
// stage fills; in_ready then drops until out_ready returns.
// Reset clears both stages, loads the register reset values and marks every
// palette entry as unwritten, so it reads as zero; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_mode_pixel_converter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bmpc_pkg::CFG_AW-1:0]   cfg_index,
	input  wire logic [bmpc_pkg::CFG_DW-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          kind,
	input  wire logic [7:0]                    entry_index,
	input  wire logic [15:0]                   entry_color,
	input  wire logic [15:0]                   pixel_word,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [31:0]                   pixel_out
);

	logic [bmpc_pkg::MODE_W-1:0] mode_q;
	logic bg2_q;
	bmpc_pkg::pack_cfg_t pack_cfg_q;

	logic valid_s1;
	logic kind_s1;
	logic in_range_s1;
	logic [bmpc_pkg::COLOR_W-1:0] word_s1;

	logic out_valid_q;
	logic [31:0] pixel_q;

	logic accept;
	logic advance;
	logic wr_in_range;
	logic rd_in_range;
	logic emit_s1;
	bmpc_pkg::pal_wr_t pal_wr;
	logic [bmpc_pkg::COLOR_W-1:0] pal_data;
	logic [bmpc_pkg::COLOR_W-1:0] color_s1;
	logic [31:0] packed_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q                 <= '0;
			bg2_q                  <= 1'b0;
			pack_cfg_q.depth_is_32 <= 1'b0;
			pack_cfg_q.red         <= bmpc_pkg::make_up(bmpc_pkg::RED_MASK_RST);
			pack_cfg_q.green       <= bmpc_pkg::make_up(bmpc_pkg::GREEN_MASK_RST);
			pack_cfg_q.blue        <= bmpc_pkg::make_dn(bmpc_pkg::BLUE_MASK_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmpc_pkg::REG_SCREEN_MODE: mode_q <= cfg_wdata[bmpc_pkg::MODE_W-1:0];
				bmpc_pkg::REG_BG2_ENABLE:  bg2_q <= cfg_wdata[0];
				bmpc_pkg::REG_DEPTH_IS_32: pack_cfg_q.depth_is_32 <= cfg_wdata[0];
				bmpc_pkg::REG_RED_MASK:    pack_cfg_q.red <= bmpc_pkg::make_up(cfg_wdata);
				bmpc_pkg::REG_GREEN_MASK:  pack_cfg_q.green <= bmpc_pkg::make_up(cfg_wdata);
				bmpc_pkg::REG_BLUE_MASK:   pack_cfg_q.blue <= bmpc_pkg::make_dn(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	assign wr_in_range = {24'd0, entry_index} < 32'(bmpc_pkg::PAL_ENTRIES);
	assign rd_in_range = {24'd0, pixel_word[7:0]} < 32'(bmpc_pkg::PAL_ENTRIES);

	always_comb begin
		pal_wr.en   = accept && (kind == bmpc_pkg::KIND_PAL_WRITE) && wr_in_range;
		pal_wr.addr = entry_index[bmpc_pkg::PAL_AW-1:0];
		pal_wr.data = entry_color[bmpc_pkg::COLOR_W-1:0];
	end

	bmpc_palette u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_en   (accept && (kind == bmpc_pkg::KIND_PIXEL)),
		.rd_addr (pixel_word[bmpc_pkg::PAL_AW-1:0]),
		.rd_data (pal_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			in_range_s1 <= rd_in_range;
			word_s1     <= pixel_word[bmpc_pkg::COLOR_W-1:0];
		end
	end

	always_comb begin
		emit_s1 = valid_s1 && (kind_s1 == bmpc_pkg::KIND_PIXEL) && bg2_q &&
			((mode_q == bmpc_pkg::MODE_DIRECT) || (mode_q == bmpc_pkg::MODE_PALETTE));
		if (mode_q == bmpc_pkg::MODE_DIRECT) begin
			color_s1 = word_s1;
		end else if (in_range_s1) begin
			color_s1 = pal_data;
		end else begin
			color_s1 = '0;
		end
	end

	bmpc_pack u_pack (
		.color (color_s1),
		.cfg   (pack_cfg_q),
		.pixel (packed_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_s1) begin
			pixel_q <= packed_pixel;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;

	// An accepted transaction always lands in the input stage.
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction did not reach the input stage");

	// Backpressure only comes from a full input stage behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a stalled output");

	// A pixel to be shown reaches the output register when it is free.
	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s1 && advance) |=> out_valid_q)
		else $error("shown pixel was lost between stages");

	// Palette writes never produce an output transaction.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (kind_s1 == bmpc_pkg::KIND_PAL_WRITE) && advance) |=> !out_valid_q)
		else $error("palette write produced an output transaction");

endmodule

`default_nettype wire
